// ----- sv/rbd_pkg.sv -----
// rbd_pkg: shared types, codes and defaults for the reconnect burst detector.
// No dependencies; imported by rbd_cell, rbd_head and reconnect_burst_detector.
package rbd_pkg;

  localparam int RBD_TABLE_ENTRIES = 16;

  localparam int RBD_CFG_IDX_W  = 1;
  localparam int RBD_CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [RBD_CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 1'd0;
  localparam logic [RBD_CFG_IDX_W-1:0] REG_WINDOW_SECONDS  = 1'd1;

  localparam logic [15:0] COUNT_THRESHOLD_RST = 16'd5;
  localparam logic [31:0] WINDOW_SECONDS_RST  = 32'd15;
  localparam logic [15:0] COUNT_MAX           = 16'hFFFF;

  // result outcome codes
  localparam logic [1:0] OUT_COUNTED = 2'd0;
  localparam logic [1:0] OUT_ALARM   = 2'd1;
  localparam logic [1:0] OUT_NEW     = 2'd2;
  localparam logic [1:0] OUT_DROPPED = 2'd3;

  typedef struct packed {
    logic [63:0] host_key;
    logic [31:0] event_time;
  } rbd_in_t;

  typedef struct packed {
    logic        alarm;
    logic [1:0]  outcome;
    logic [3:0]  slot;
    logic [15:0] hit_count;
  } rbd_out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] count;
    logic [31:0] first_time;
  } rbd_entry_t;

  // sequencer -> head evaluator
  typedef struct packed {
    logic fill_pass;  // 0: search pass, 1: expire/fill pass
    logic done;       // request already resolved in this pass
  } rbd_head_ctl_t;

  // head evaluator -> sequencer
  typedef struct packed {
    logic        hit;    // matched (search) or filled (fill)
    logic        alarm;
    logic [15:0] count;
  } rbd_head_sts_t;

endpackage

// ----- sv/rbd_cell.sv -----
// rbd_cell: one table entry in the rotating ring of entries.
// Depends on rbd_pkg (rbd_entry_t).
module rbd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  rbd_pkg::rbd_entry_t d,
  output rbd_pkg::rbd_entry_t q
);
  import rbd_pkg::*;

  logic        valid_r;
  logic [63:0] key_r;
  logic [15:0] count_r;
  logic [31:0] first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
    end
  end

  // payload: only looked at while valid
  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r   <= d.key;
      count_r <= d.count;
      first_r <= d.first_time;
    end
  end

  assign q = '{valid: valid_r, key: key_r, count: count_r, first_time: first_r};

endmodule

// ----- sv/rbd_head.sv -----
// rbd_head: evaluates the entry at the head of the ring and builds its write-back.
// Depends on rbd_pkg (entry, control and status types).
module rbd_head (
  input  rbd_pkg::rbd_entry_t    head,
  input  logic [63:0]            key,
  input  logic [31:0]            now,
  input  logic [15:0]            threshold,
  input  logic [31:0]            window,
  input  rbd_pkg::rbd_head_ctl_t ctl,
  output rbd_pkg::rbd_entry_t    wb,
  output rbd_pkg::rbd_head_sts_t sts
);
  import rbd_pkg::*;

  logic [31:0] age;
  logic        in_window;
  logic        match;
  logic [15:0] cnt_inc;
  logic        burst;
  logic        expired;
  logic        take;

  assign age       = now - head.first_time;  // wraps mod 2^32
  assign in_window = (age <= window);
  assign match     = !ctl.fill_pass && !ctl.done && head.valid && (head.key == key);
  assign cnt_inc   = (head.count == COUNT_MAX) ? head.count : head.count + 16'd1;
  assign burst     = match && (cnt_inc > threshold) && in_window;
  assign expired   = ctl.fill_pass && head.valid && !in_window;
  assign take      = ctl.fill_pass && !ctl.done && (!head.valid || expired);

  always_comb begin
    wb = head;
    if (match) begin
      wb.count = cnt_inc;
    end
    if (burst || expired) begin
      wb.valid      = 1'b0;
      wb.count      = '0;
      wb.first_time = '0;
    end
    if (take) begin
      wb.valid      = 1'b1;
      wb.key        = key;
      wb.count      = 16'd1;
      wb.first_time = now;
    end
  end

  always_comb begin
    sts.hit   = match || take;
    sts.alarm = burst;
    if (take) begin
      sts.count = 16'd1;
    end else if (burst) begin
      sts.count = '0;
    end else begin
      sts.count = cnt_inc;
    end
  end

endmodule

// ----- sv/reconnect_burst_detector.sv -----
// reconnect_burst_detector: top level, a ring of entry cells, head evaluator,
// sequencer and config registers. Depends on rbd_pkg, rbd_cell, rbd_head.
//
// Reconnect burst detector. A request (host key, time in seconds) is taken
// when start is high and busy is low. The table is a ring of TABLE_ENTRIES
// cells that rotates by one entry per cycle while busy; the entry at the
// head is checked and written back at the tail, so one full rotation visits
// every entry in index order and leaves the table in place. The first
// rotation looks for the key; on a hit the count is bumped (saturating) or,
// above the threshold and within the window, an alarm is raised and the
// entry freed. On a miss a second rotation expires entries older than the
// window and places the key in the lowest free entry, else the request is
// dropped. Busy stays high through the search rotation, and through the
// fill rotation as well on a miss. The result shows on out_data for exactly
// one cycle with out_valid high, the cycle busy falls, and must be taken
// then: there is no backpressure on the result side. A new request may start
// in that same cycle. Config writes (cfg_ready is always high) belong in idle
// time only. No clearing pass is needed after reset.
module reconnect_burst_detector #(
  parameter int TABLE_ENTRIES = rbd_pkg::RBD_TABLE_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  rbd_pkg::rbd_in_t                     in_data,
  // result channel
  output logic                                 out_valid,
  output rbd_pkg::rbd_out_t                    out_data,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbd_pkg::RBD_CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbd_pkg::RBD_CFG_DATA_W-1:0]   cfg_data
);
  import rbd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FILL   = 2'd2;

  // sequencer
  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             done_r, done_nxt;
  rbd_in_t          req_r, req_nxt;
  rbd_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  rbd_out_t         out_data_r, out_data_nxt;

  // config
  logic [15:0]      thr_r;
  logic [31:0]      win_r;

  // ring
  rbd_entry_t       cell_q [TABLE_ENTRIES];
  rbd_entry_t       wb;
  logic             shift_en;
  rbd_head_ctl_t    head_ctl;
  rbd_head_sts_t    head_sts;
  logic             accept;
  logic             last;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign shift_en  = busy;
  assign last      = (idx_r == IDX_LAST);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ring: cell k takes from cell k+1, the tail takes the head's write-back
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    rbd_entry_t d;
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign d = wb;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    rbd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (d),
      .q        (cell_q[k])
    );
  end

  assign head_ctl = '{fill_pass: (state_r == ST_FILL), done: done_r};

  rbd_head u_head (
    .head      (cell_q[0]),
    .key       (req_r.host_key),
    .now       (req_r.event_time),
    .threshold (thr_r),
    .window    (win_r),
    .ctl       (head_ctl),
    .wb        (wb),
    .sts       (head_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    done_nxt      = done_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEARCH;
          idx_nxt   = '0;
          done_nxt  = 1'b0;
          req_nxt   = in_data;
          res_nxt   = '{alarm: 1'b0, outcome: OUT_DROPPED, slot: 4'd0, hit_count: 16'd0};
        end
      end
      ST_SEARCH, ST_FILL: begin
        if (head_sts.hit) begin
          done_nxt          = 1'b1;
          res_nxt.alarm     = head_sts.alarm;
          res_nxt.slot      = 4'(idx_r);
          res_nxt.hit_count = head_sts.count;
          if (state_r == ST_FILL) begin
            res_nxt.outcome = OUT_NEW;
          end else if (head_sts.alarm) begin
            res_nxt.outcome = OUT_ALARM;
          end else begin
            res_nxt.outcome = OUT_COUNTED;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (last) begin
          idx_nxt = '0;
          if (state_r == ST_SEARCH && !done_nxt) begin
            // miss: second rotation to expire and fill
            state_nxt = ST_FILL;
            done_nxt  = 1'b0;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_data_nxt  = res_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= COUNT_THRESHOLD_RST;
      win_r <= WINDOW_SECONDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNT_THRESHOLD: thr_r <= cfg_data[15:0];
        REG_WINDOW_SECONDS:  win_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // the result strobe only comes as the sequencer returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // a whole busy rotation lies between two strobes, so strobes never touch
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alarm == (out_data.outcome == OUT_ALARM)))
    else $error("alarm flag disagrees with outcome");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outcome == OUT_DROPPED) |->
      (out_data.slot == 4'd0 && out_data.hit_count == 16'd0))
    else $error("dropped request carries slot or count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

// ----- test/tb_reconnect_burst_detector.sv -----
// tb_reconnect_burst_detector: self-checking testbench for the reconnect burst detector.
// Depends on rbd_pkg and reconnect_burst_detector; a built-in host table model predicts results.
`timescale 1ns / 1ps

module tb_reconnect_burst_detector;
  import rbd_pkg::*;

  localparam int N_ENTRIES   = RBD_TABLE_ENTRIES;
  // Sized for the worst case: every request a full miss scan plus the
  // longest idle gap.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 255;
  localparam int POOL_KEYS   = 20;  // a few more than the table holds, so it fills up
  localparam int MAX_REPORTS = 40;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  rbd_in_t                     in_data;
  logic                        out_valid;
  rbd_out_t                    out_data;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [RBD_CFG_IDX_W-1:0]    cfg_index;
  logic [RBD_CFG_DATA_W-1:0]   cfg_data;

  reconnect_burst_detector #(
    .TABLE_ENTRIES(N_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Host table model, mirrors the block's state.
  logic        host_valid [N_ENTRIES];
  logic [63:0] host_key   [N_ENTRIES];
  logic [15:0] host_count [N_ENTRIES];
  logic [31:0] host_first [N_ENTRIES];
  logic [15:0] model_threshold;
  logic [31:0] model_window;

  // Outcomes of accepted requests, oldest first.
  rbd_out_t pending_outcomes [$];

  int unsigned cycle_count = 0;
  int          err_count;
  int          sent_count;
  int          checked_count;
  int          settings_count;
  int          outcome_seen [4];
  bit          idle_enable;

  // 20 ns clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a missing result ends up here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_outcomes.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS)
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Predicted result of one event; updates the host table model.
  function automatic rbd_out_t detector_outcome(input rbd_in_t ev);
    rbd_out_t    res;
    logic [31:0] age;
    int          i;
    res = '0;
    // search pass: a matching live entry takes the hit
    for (i = 0; i < N_ENTRIES; i++) begin
      if (host_valid[i] && host_key[i] == ev.host_key) begin
        age = ev.event_time - host_first[i];   // wraps mod 2^32
        if (host_count[i] != COUNT_MAX)
          host_count[i] = host_count[i] + 16'd1;
        res.slot = 4'(i);
        // age equal to the window still counts as inside it
        if (host_count[i] > model_threshold && age <= model_window) begin
          host_valid[i] = 1'b0;
          host_count[i] = '0;
          host_first[i] = '0;
          res.alarm     = 1'b1;
          res.outcome   = OUT_ALARM;
        end else begin
          // stale burst lands here too: no expiry on the hit path
          res.outcome   = OUT_COUNTED;
          res.hit_count = host_count[i];
        end
        return res;
      end
    end
    // miss: drop entries strictly older than the window
    for (i = 0; i < N_ENTRIES; i++) begin
      age = ev.event_time - host_first[i];
      if (host_valid[i] && age > model_window) begin
        host_valid[i] = 1'b0;
        host_count[i] = '0;
        host_first[i] = '0;
      end
    end
    // then claim the lowest free entry
    for (i = 0; i < N_ENTRIES; i++) begin
      if (!host_valid[i]) begin
        host_valid[i] = 1'b1;
        host_key[i]   = ev.host_key;
        host_first[i] = ev.event_time;
        host_count[i] = 16'd1;
        res.outcome   = OUT_NEW;
        res.slot      = 4'(i);
        res.hit_count = 16'd1;
        return res;
      end
    end
    res.outcome = OUT_DROPPED;
    return res;
  endfunction

  // Result checker. The receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    rbd_out_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result strobe with no pending request");
      end else begin
        want = pending_outcomes.pop_front();
        checked_count++;
        outcome_seen[want.outcome]++;
        if (out_data.alarm !== want.alarm)
          report_mismatch($sformatf("alarm got %b want %b", out_data.alarm, want.alarm));
        if (out_data.outcome !== want.outcome)
          report_mismatch($sformatf("outcome got %0d want %0d",
                                    out_data.outcome, want.outcome));
        if (out_data.slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d", out_data.slot, want.slot));
        if (out_data.hit_count !== want.hit_count)
          report_mismatch($sformatf("hit_count got %0d want %0d",
                                    out_data.hit_count, want.hit_count));
      end
    end
  end

  // Idle length between requests: mostly none, some short, a few much
  // longer.
  function automatic int gap_cycles();
    int r;
    if (!idle_enable)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(17, 70);
  endfunction

  // One request. start stays high on return so a following request can go
  // back to back; the caller lowers it if it idles.
  task automatic send_event(input logic [63:0] key, input logic [31:0] stamp);
    rbd_in_t ev;
    ev.host_key   = key;
    ev.event_time = stamp;
    start   <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(detector_outcome(ev));
    sent_count++;
  endtask

  task automatic push_event(input logic [63:0] key, input logic [31:0] stamp);
    int n;
    send_event(key, stamp);
    n = gap_cycles();
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom};  // junk while idle
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain: every accepted request has produced its result.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic set_config(input logic [31:0] thr_word, input logic [31:0] win);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_COUNT_THRESHOLD;
    cfg_data  <= thr_word;
    do @(posedge clk); while (!cfg_ready);
    model_threshold = thr_word[15:0];
    cfg_index <= REG_WINDOW_SECONDS;
    cfg_data  <= win;
    do @(posedge clk); while (!cfg_ready);
    model_window = win;
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Reset values: count up to the threshold, then the alarm fires on a hit
  // whose age equals the window exactly, across a time wrap.
  task automatic test_alarm_at_window_edge();
    logic [63:0] k;
    k = '1;
    push_event(k, 32'hFFFF_FFFF);
    push_event(k, 32'd0);
    push_event(k, 32'd5);
    push_event(k, 32'd10);
    push_event(k, 32'd13);
    push_event(k, 32'd14);   // count 6 > 5, age 15 == window
  endtask

  // Threshold and window at zero: stale burst, time going backwards, expiry
  // at age window+1 but not at age equal to it.
  task automatic test_zero_settings();
    logic [63:0] k2, k3;
    k2 = {$urandom, $urandom};
    k3 = {$urandom, $urandom};
    set_config(32'd0, 32'd0);
    push_event(64'd0, 32'd100);
    push_event(64'd0, 32'd101);  // above threshold but outside window
    push_event(64'd0, 32'd99);   // earlier time reads as a huge age
    push_event(k2, 32'd100);     // key 0 at age 0 survives
    push_event(k3, 32'd101);     // both older entries expire
    push_event(k3, 32'd101);     // age 0, alarm
  endtask

  // Fill every entry, overflow once, then let the whole table age out.
  task automatic test_table_full();
    int i;
    set_config(32'd5, 32'd1000);
    for (i = 0; i < N_ENTRIES; i++)
      push_event({$urandom, $urandom}, 32'd500);
    push_event({$urandom, $urandom}, 32'd1500);  // age 1000, nothing expires
    push_event({$urandom, $urandom}, 32'd1501);  // all expire, lowest slot
  endtask

  // Top threshold: a long run of hits never alarms; then a threshold just
  // under the running count makes the next hit alarm.
  task automatic test_high_threshold();
    logic [63:0] k;
    int i;
    k = {$urandom, $urandom};
    set_config(32'hFFFF, 32'hFFFF_FFFF);
    idle_enable = 1'b0;
    for (i = 0; i < 40; i++)
      push_event(k, 32'(i));
    set_config(32'd39, 32'hFFFF_FFFF);
    push_event(k, 32'd5);    // count 41 > 39, age 5
    idle_enable = 1'b1;
  endtask

  // Random traffic for one register setting: bursts from a small key pool,
  // with fresh keys, time jumps, backward steps and random times mixed in.
  task automatic run_random_phase(input logic [31:0] thr_word, input logic [31:0] win,
                                  input int n_items, input bit idle_on);
    logic [63:0] pool [POOL_KEYS];
    logic [31:0] now;
    int unsigned step_max, jump_max;
    int          i, r, burst, done;
    logic [63:0] k;
    set_config(thr_word, win);
    idle_enable = idle_on;
    for (i = 0; i < POOL_KEYS; i++)
      pool[i] = {$urandom, $urandom};
    now      = $urandom;
    step_max = (win > 8000) ? 1000 : win / 8 + 1;
    jump_max = (win > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : 2 * win + 2;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k     = pool[$urandom_range(0, POOL_KEYS - 1)];
        burst = $urandom_range(1, 8);
        for (i = 0; i < burst; i++) begin
          now = now + $urandom_range(0, step_max);
          push_event(k, now);
        end
        done += burst;
      end else begin
        if (r < 75) begin
          k = {$urandom, $urandom};
        end else begin
          k = pool[$urandom_range(0, POOL_KEYS - 1)];
          if (r < 85)
            now = now + $urandom_range(0, jump_max);
          else if (r < 90)
            now = now - $urandom_range(1, 20);
          else
            now = $urandom;
        end
        push_event(k, now);
        done++;
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    int i;
    // known values on every input from time zero, while reset is held low
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COUNT_THRESHOLD;
    cfg_data  <= '0;
    err_count      = 0;
    sent_count     = 0;
    checked_count  = 0;
    settings_count = 0;
    idle_enable    = 1'b1;
    for (i = 0; i < 4; i++)
      outcome_seen[i] = 0;
    for (i = 0; i < N_ENTRIES; i++) begin
      host_valid[i] = 1'b0;
      host_key[i]   = '0;
      host_count[i] = '0;
      host_first[i] = '0;
    end
    model_threshold = COUNT_THRESHOLD_RST;
    model_window    = WINDOW_SECONDS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_alarm_at_window_edge();
    test_zero_settings();
    test_table_full();
    test_high_threshold();

    run_random_phase(32'd5, 32'd15, PHASE_ITEMS, 1'b1);
    run_random_phase(32'd0, 32'd0, PHASE_ITEMS, 1'b1);
    run_random_phase(32'd2, 32'd3, PHASE_ITEMS, 1'b0);
    // junk in the upper half of the threshold word must be ignored
    run_random_phase({16'($urandom), 16'd1}, 32'd40, PHASE_ITEMS, 1'b1);
    run_random_phase(32'hFFFF, 32'hFFFF_FFFF, PHASE_ITEMS, 1'b1);
    run_random_phase($urandom_range(0, 12), $urandom_range(0, 60), PHASE_ITEMS, 1'b1);
    run_random_phase($urandom, $urandom, PHASE_ITEMS, 1'b1);

    // drain, then leave time for any stray strobe
    wait_idle();
    repeat (2 * N_ENTRIES + 4) @(posedge clk);

    $display("tb: %0d requests sent under %0d register settings, %0d results compared",
             sent_count, settings_count, checked_count);
    $display("tb: %0d counted, %0d alarms, %0d new entries, %0d dropped, %0d mismatches",
             outcome_seen[OUT_COUNTED], outcome_seen[OUT_ALARM], outcome_seen[OUT_NEW],
             outcome_seen[OUT_DROPPED], err_count);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
